>>> design/median3x3_by_intensity_defines.svh
// Assertion macros shared by the median filter checker.
// No dependencies; include with the bare file name.
`ifndef MEDIAN3X3_BY_INTENSITY_DEFINES_SVH
`define MEDIAN3X3_BY_INTENSITY_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MED3_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("median3x3 check failed");

// Next-cycle implication, disabled while reset is high.
`define MED3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("median3x3 check failed");

`endif

>>> design/med3_pkg.sv
// Shared types and constants for the 3x3 median-by-intensity filter.
// No dependencies.
package med3_pkg;

   localparam int WinSize    = 9;
   localparam int MedianRank = 4;
   localparam int PixWidth   = 24;
   localparam int ChanWidth  = 8;
   localparam int KeyWidth   = 8;
   localparam int SumWidth   = 10;
   localparam int RankWidth  = 4;

   // floor(sum / 3) == (sum * 683) >> 11 for every sum up to 765
   localparam int DivRecip   = 683;
   localparam int DivShift   = 11;
   localparam int ProdWidth  = SumWidth + SumWidth;

   typedef logic [PixWidth-1:0]  pixel_type;
   typedef logic [KeyWidth-1:0]  key_type;
   typedef logic [RankWidth-1:0] rank_type;

endpackage

>>> design/med3_key.sv
// Intensity key of one packed RGB pixel: floor((r + g + b) / 3).
// Depends on med3_pkg.
module med3_key (
   input  med3_pkg::pixel_type pixel,
   output med3_pkg::key_type   key
);
   import med3_pkg::*;

   logic [SumWidth-1:0]  chan_sum;
   logic [ProdWidth-1:0] scaled;

   // Add the three channels
   assign chan_sum = SumWidth'(pixel[23:16]) + SumWidth'(pixel[15:8])
                   + SumWidth'(pixel[7:0]);

   // Divide by three through the reciprocal
   assign scaled = ProdWidth'(chan_sum) * ProdWidth'(DivRecip);
   assign key    = scaled[DivShift +: KeyWidth];

endmodule

>>> design/med3_rank_sel.sv
// Stable rank of each window pixel by key, and selection of the median pixel.
// Depends on med3_pkg.
module med3_rank_sel (
   input  med3_pkg::pixel_type pix [med3_pkg::WinSize],
   input  med3_pkg::key_type   key [med3_pkg::WinSize],
   output med3_pkg::pixel_type median
);
   import med3_pkg::*;

   rank_type  rank [WinSize];
   pixel_type pick;

   // Count smaller keys plus equal keys earlier in the window
   always_comb begin
      for (int a = 0; a < WinSize; a++) begin
         rank[a] = '0;
         for (int b = 0; b < WinSize; b++) begin
            if ((key[b] < key[a]) || ((key[b] == key[a]) && (b < a))) begin
               rank[a] = rank[a] + rank_type'(1);
            end
         end
      end
   end

   // Ranks form a permutation, so exactly one pixel matches
   always_comb begin
      pick = '0;
      for (int a = 0; a < WinSize; a++) begin
         if (rank[a] == rank_type'(MedianRank)) begin
            pick = pick | pix[a];
         end
      end
   end

   assign median = pick;

endmodule

>>> design/median3x3_by_intensity.sv
// Two pipeline stages: the key register, then the result register.
// Throughput: one window per cycle unless stalled; stages advance independently.
// Reset: synchronous, active high; clears both stage valid bits, data not reset.
// Depends on med3_pkg, med3_key, med3_rank_sel.
module median3x3_by_intensity (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  med3_pkg::pixel_type req_pix_left_up,
   input  med3_pkg::pixel_type req_pix_left_mid,
   input  med3_pkg::pixel_type req_pix_left_down,
   input  med3_pkg::pixel_type req_pix_mid_up,
   input  med3_pkg::pixel_type req_pix_center,
   input  med3_pkg::pixel_type req_pix_mid_down,
   input  med3_pkg::pixel_type req_pix_right_up,
   input  med3_pkg::pixel_type req_pix_right_mid,
   input  med3_pkg::pixel_type req_pix_right_down,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output med3_pkg::pixel_type rsp_median_pixel
);
   import med3_pkg::*;

   pixel_type win_pix [WinSize];
   key_type   win_key [WinSize];

   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_pix_ff [WinSize];
   key_type   s1_key_ff [WinSize];

   logic      s2_valid_ff, s2_valid_in;
   pixel_type s2_pix_ff, s2_pix_in;

   logic      req_accept;
   logic      s1_move;

   // Gather the window in column order
   assign win_pix[0] = req_pix_left_up;
   assign win_pix[1] = req_pix_left_mid;
   assign win_pix[2] = req_pix_left_down;
   assign win_pix[3] = req_pix_mid_up;
   assign win_pix[4] = req_pix_center;
   assign win_pix[5] = req_pix_mid_down;
   assign win_pix[6] = req_pix_right_up;
   assign win_pix[7] = req_pix_right_mid;
   assign win_pix[8] = req_pix_right_down;

   // Compute one key per pixel
   for (genvar i = 0; i < WinSize; i++) begin : g_key
      med3_key u_key (
         .pixel (win_pix[i]),
         .key   (win_key[i])
      );
   end

   // Advance stage one when the result register is free or being drained
   assign s1_move    = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && s2_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in = req_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_move ? 1'b1 : ((s2_valid_ff && !rsp_stall) ? 1'b0 : s2_valid_ff);

   // Hold the valid bits of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture pixels and keys of an accepted request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff <= win_pix;
         s1_key_ff <= win_key;
      end
   end

   // Rank the window and pick the median
   med3_rank_sel u_rank_sel (
      .pix    (s1_pix_ff),
      .key    (s1_key_ff),
      .median (s2_pix_in)
   );

   // Load the result register as stage one advances
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_pix_ff <= s2_pix_in;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_median_pixel = s2_pix_ff;

endmodule

>>> design/med3_checker.sv
// Port-level checks for the median filter, bound to the top level.
// Depends on med3_pkg and median3x3_by_intensity_defines.svh.
`include "median3x3_by_intensity_defines.svh"

module med3_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input med3_pkg::pixel_type rsp_median_pixel
);
   import med3_pkg::*;

   // A stalled result stays valid and unchanged
   `MED3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_median_pixel))

   // Back-pressure on requests only comes from a stalled, waiting result
   `MED3_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // An accepted request is followed by a valid result once past the stage-one register (an older one if stalled)
   `MED3_ASSERT_NEXT(a_result_due, clock, reset, req_valid && !req_stall, ##1 rsp_valid)

endmodule

bind median3x3_by_intensity med3_checker u_med3_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_median_pixel (rsp_median_pixel)
);
